// ===== sv/transitive_closure_cycle_check_core_macros.svh =====
// Assertion macros for the transitive closure cycle check core.
// Used by the top level; relies on clk and rst_n being in scope.
`ifndef TRANSITIVE_CLOSURE_CYCLE_CHECK_CORE_MACROS_SVH
`define TRANSITIVE_CLOSURE_CYCLE_CHECK_CORE_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define TCCC_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define TCCC_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== sv/tccc_pkg.sv =====
// Shared types and codes for the transitive closure cycle check core.
// No dependencies; imported by the controller, datapath and top level.
package tccc_pkg;

    localparam logic CMD_ADD_EDGE = 1'b0;
    localparam logic CMD_CHECK    = 1'b1;

    localparam logic [1:0] STATUS_ADDED   = 2'd0;
    localparam logic [1:0] STATUS_FULL    = 2'd1;
    localparam logic [1:0] STATUS_NO_LOOP = 2'd2;
    localparam logic [1:0] STATUS_LOOP    = 2'd3;

    typedef struct packed {
        logic        command;
        logic [15:0] caller_id;
        logic [15:0] callee_id;
    } tccc_req_t;

    typedef struct packed {
        logic [1:0]  status;
        logic [15:0] first_id;
        logic [15:0] second_id;
    } tccc_rsp_t;

    typedef enum logic [4:0] {
        OP_NONE,
        OP_LOAD,
        OP_SCAN,
        OP_DECIDE,
        OP_ADD_CE,
        OP_ROW1_RD,
        OP_ROW1_WR,
        OP_ROW2_RD,
        OP_ROW2_WR,
        OP_CL_RDK,
        OP_CL_LDK,
        OP_CL_ROW,
        OP_K_NEXT,
        OP_CHK_INIT,
        OP_CHK_RDI,
        OP_CHK_LDI,
        OP_CHK_ROW,
        OP_I_NEXT,
        OP_ID1_RD,
        OP_ID1_LD,
        OP_ID2_LD,
        OP_SET_NOLOOP,
        OP_PUSH
    } dp_op_t;

    typedef struct packed {
        dp_op_t op;
    } dp_cmd_t;

    typedef struct packed {
        logic is_check;
        logic count_zero;
        logic i_at_end;
        logic j_at_end;
        logic full;
        logic one_row;
        logic k_last;
        logic small_graph;
        logic hit;
        logic i_last;
        logic out_free;
    } dp_status_t;

    typedef enum logic [4:0] {
        S_IDLE,
        S_DISPATCH,
        S_SCAN,
        S_DECIDE,
        S_ADD_CE,
        S_ROW1_RD,
        S_ROW1_WR,
        S_ROW2_RD,
        S_ROW2_WR,
        S_CL_RDK,
        S_CL_LDK,
        S_CL_ROW,
        S_CHK_START,
        S_CHK_RDI,
        S_CHK_LDI,
        S_CHK_ROW,
        S_CHK_NEXT,
        S_ID1_RD,
        S_ID1_LD,
        S_ID2_LD,
        S_DONE
    } ctrl_state_t;

endpackage

// ===== sv/tccc_ctrl.sv =====
// Sequencing state machine for the transitive closure cycle check core.
// Depends on tccc_pkg; drives datapath operations from datapath status.
module tccc_ctrl
    import tccc_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       req_valid,
    output logic       req_ready,
    input  dp_status_t sts,
    output dp_cmd_t    cmd
);

    ctrl_state_t state_reg;
    ctrl_state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd.op     = OP_NONE;
        req_ready  = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                req_ready = 1'b1;
                if (req_valid)
                begin
                    cmd.op     = OP_LOAD;
                    state_next = S_DISPATCH;
                end
            end
            S_DISPATCH:
            begin
                if (!sts.is_check)
                begin
                    state_next = S_SCAN;
                end
                else if (sts.count_zero)
                begin
                    state_next = S_CHK_START;
                end
                else
                begin
                    state_next = S_CL_RDK;
                end
            end
            S_SCAN:
            begin
                // The compare of the last entry read lands in the cycle that leaves.
                if (!sts.i_at_end)
                begin
                    cmd.op = OP_SCAN;
                end
                else
                begin
                    state_next = S_DECIDE;
                end
            end
            S_DECIDE:
            begin
                cmd.op     = OP_DECIDE;
                state_next = sts.full ? S_DONE : S_ADD_CE;
            end
            S_ADD_CE:
            begin
                cmd.op     = OP_ADD_CE;
                state_next = S_ROW1_RD;
            end
            S_ROW1_RD:
            begin
                cmd.op     = OP_ROW1_RD;
                state_next = S_ROW1_WR;
            end
            S_ROW1_WR:
            begin
                cmd.op     = OP_ROW1_WR;
                state_next = sts.one_row ? S_DONE : S_ROW2_RD;
            end
            S_ROW2_RD:
            begin
                cmd.op     = OP_ROW2_RD;
                state_next = S_ROW2_WR;
            end
            S_ROW2_WR:
            begin
                cmd.op     = OP_ROW2_WR;
                state_next = S_DONE;
            end
            S_CL_RDK:
            begin
                cmd.op     = OP_CL_RDK;
                state_next = S_CL_LDK;
            end
            S_CL_LDK:
            begin
                cmd.op     = OP_CL_LDK;
                state_next = S_CL_ROW;
            end
            S_CL_ROW:
            begin
                if (!sts.i_at_end)
                begin
                    cmd.op = OP_CL_ROW;
                end
                else if (sts.k_last)
                begin
                    state_next = S_CHK_START;
                end
                else
                begin
                    cmd.op     = OP_K_NEXT;
                    state_next = S_CL_RDK;
                end
            end
            S_CHK_START:
            begin
                if (sts.small_graph)
                begin
                    cmd.op     = OP_SET_NOLOOP;
                    state_next = S_DONE;
                end
                else
                begin
                    cmd.op     = OP_CHK_INIT;
                    state_next = S_CHK_RDI;
                end
            end
            S_CHK_RDI:
            begin
                cmd.op     = OP_CHK_RDI;
                state_next = S_CHK_LDI;
            end
            S_CHK_LDI:
            begin
                cmd.op     = OP_CHK_LDI;
                state_next = S_CHK_ROW;
            end
            S_CHK_ROW:
            begin
                if (!sts.j_at_end)
                begin
                    cmd.op = OP_CHK_ROW;
                end
                else
                begin
                    state_next = S_CHK_NEXT;
                end
            end
            S_CHK_NEXT:
            begin
                if (sts.hit)
                begin
                    state_next = S_ID1_RD;
                end
                else if (sts.i_last)
                begin
                    cmd.op     = OP_SET_NOLOOP;
                    state_next = S_DONE;
                end
                else
                begin
                    cmd.op     = OP_I_NEXT;
                    state_next = S_CHK_RDI;
                end
            end
            S_ID1_RD:
            begin
                cmd.op     = OP_ID1_RD;
                state_next = S_ID1_LD;
            end
            S_ID1_LD:
            begin
                cmd.op     = OP_ID1_LD;
                state_next = S_ID2_LD;
            end
            S_ID2_LD:
            begin
                cmd.op     = OP_ID2_LD;
                state_next = S_DONE;
            end
            S_DONE:
            begin
                if (sts.out_free)
                begin
                    cmd.op     = OP_PUSH;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule

// ===== sv/tccc_datapath.sv =====
// Datapath of the transitive closure cycle check core: id table, reach
// matrix, counters and the output register. Depends on tccc_pkg.
module tccc_datapath
    import tccc_pkg::*;
#(
    parameter int MAX_NODES = 256,
    parameter int ID_BITS   = 16
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  tccc_req_t  req,
    input  logic       rsp_ready,
    output tccc_rsp_t  rsp,
    output logic       rsp_valid,
    input  dp_cmd_t    cmd,
    output dp_status_t sts
);

    localparam int IW = $clog2(MAX_NODES);
    localparam int CW = $clog2(MAX_NODES + 1);

    typedef logic [MAX_NODES-1:0] row_t;
    typedef logic [IW-1:0]        idx_t;
    typedef logic [CW-1:0]        cnt_t;
    typedef logic [CW:0]          wcnt_t;
    typedef logic [ID_BITS-1:0]   id_t;

    // Storage; neither is cleared. Rows are only read below the node count,
    // and a node's first row write treats the old contents as zero.
    id_t  id_mem [MAX_NODES];
    row_t row_mem [MAX_NODES];
    id_t  id_rd_reg;
    row_t row_rd_reg;

    logic id_re, id_we, row_re, row_we;
    idx_t id_raddr, id_waddr, row_raddr, row_waddr;
    id_t  id_wdata;
    row_t row_wdata;

    cnt_t count_reg, count_next;
    cnt_t i_reg, i_next;
    cnt_t j_reg, j_next;
    cnt_t k_reg, k_next;
    id_t  cr_id_reg, cr_id_next;
    id_t  ce_id_reg, ce_id_next;
    idx_t cr_idx_reg, cr_idx_next;
    idx_t ce_idx_reg, ce_idx_next;
    idx_t tag_reg, tag_next;
    idx_t hit_j_reg, hit_j_next;
    logic cr_found_reg, cr_found_next;
    logic ce_found_reg, ce_found_next;
    logic cr_new_reg, cr_new_next;
    logic ce_new_reg, ce_new_next;
    logic check_reg, check_next;
    logic hit_reg, hit_next;
    logic scan_vld_reg, scan_vld_next;
    logic cl_vld_reg, cl_vld_next;
    logic chk_vld_reg, chk_vld_next;
    row_t rowk_reg, rowk_next;
    row_t rowi_reg, rowi_next;
    logic [1:0]  res_status_reg, res_status_next;
    logic [15:0] res_first_reg, res_first_next;
    logic [15:0] res_second_reg, res_second_next;
    tccc_rsp_t   rsp_reg, rsp_next;
    logic        rsp_valid_reg, rsp_valid_next;

    logic  ce_same;
    wcnt_t need;
    wcnt_t free_slots;

    assign ce_same    = (cr_id_reg == ce_id_reg);
    assign need       = wcnt_t'(!cr_found_reg) + wcnt_t'(!ce_found_reg && !ce_same);
    assign free_slots = wcnt_t'(MAX_NODES) - wcnt_t'(count_reg);

    assign sts.is_check    = check_reg;
    assign sts.count_zero  = (count_reg == '0);
    assign sts.i_at_end    = (i_reg == count_reg);
    assign sts.j_at_end    = (j_reg == count_reg);
    assign sts.full        = (need > free_slots);
    assign sts.one_row     = (ce_idx_reg == cr_idx_reg);
    assign sts.k_last      = ((wcnt_t'(k_reg) + wcnt_t'(1)) == wcnt_t'(count_reg));
    assign sts.small_graph = (count_reg < cnt_t'(2));
    assign sts.hit         = hit_reg;
    assign sts.i_last      = ((wcnt_t'(i_reg) + wcnt_t'(2)) == wcnt_t'(count_reg));
    assign sts.out_free    = !rsp_valid_reg || rsp_ready;

    assign rsp       = rsp_reg;
    assign rsp_valid = rsp_valid_reg;

    always_comb
    begin
        count_next      = count_reg;
        i_next          = i_reg;
        j_next          = j_reg;
        k_next          = k_reg;
        cr_id_next      = cr_id_reg;
        ce_id_next      = ce_id_reg;
        cr_idx_next     = cr_idx_reg;
        ce_idx_next     = ce_idx_reg;
        tag_next        = tag_reg;
        hit_j_next      = hit_j_reg;
        cr_found_next   = cr_found_reg;
        ce_found_next   = ce_found_reg;
        cr_new_next     = cr_new_reg;
        ce_new_next     = ce_new_reg;
        check_next      = check_reg;
        hit_next        = hit_reg;
        scan_vld_next   = 1'b0;
        cl_vld_next     = 1'b0;
        chk_vld_next    = 1'b0;
        rowk_next       = rowk_reg;
        rowi_next       = rowi_reg;
        res_status_next = res_status_reg;
        res_first_next  = res_first_reg;
        res_second_next = res_second_reg;
        rsp_next        = rsp_reg;
        rsp_valid_next  = rsp_valid_reg;
        id_re           = 1'b0;
        id_we           = 1'b0;
        id_raddr        = i_reg[IW-1:0];
        id_waddr        = count_reg[IW-1:0];
        id_wdata        = cr_id_reg;
        row_re          = 1'b0;
        row_we          = 1'b0;
        row_raddr       = i_reg[IW-1:0];
        row_waddr       = tag_reg;
        row_wdata       = row_rd_reg | rowk_reg;

        if (rsp_valid_reg && rsp_ready)
        begin
            rsp_valid_next = 1'b0;
        end

        // Second half of the pipelined passes: act on the row or entry read
        // in the previous cycle, tagged with its index.
        if (scan_vld_reg)
        begin
            if (!cr_found_reg && id_rd_reg == cr_id_reg)
            begin
                cr_found_next = 1'b1;
                cr_idx_next   = tag_reg;
            end
            if (!ce_found_reg && id_rd_reg == ce_id_reg)
            begin
                ce_found_next = 1'b1;
                ce_idx_next   = tag_reg;
            end
        end
        if (cl_vld_reg && row_rd_reg[k_reg[IW-1:0]])
        begin
            row_we = 1'b1;
        end
        if (chk_vld_reg && !hit_reg && row_rd_reg[i_reg[IW-1:0]] && rowi_reg[tag_reg])
        begin
            hit_next   = 1'b1;
            hit_j_next = tag_reg;
        end

        case (cmd.op)
            OP_LOAD:
            begin
                cr_id_next      = id_t'(req.caller_id);
                ce_id_next      = id_t'(req.callee_id);
                check_next      = (req.command == CMD_CHECK);
                i_next          = '0;
                j_next          = '0;
                k_next          = '0;
                cr_found_next   = 1'b0;
                ce_found_next   = 1'b0;
                cr_new_next     = 1'b0;
                ce_new_next     = 1'b0;
                hit_next        = 1'b0;
                res_status_next = STATUS_ADDED;
                res_first_next  = '0;
                res_second_next = '0;
            end
            OP_SCAN:
            begin
                id_re         = 1'b1;
                tag_next      = i_reg[IW-1:0];
                scan_vld_next = 1'b1;
                i_next        = i_reg + cnt_t'(1);
            end
            OP_DECIDE:
            begin
                if (sts.full)
                begin
                    res_status_next = STATUS_FULL;
                end
                else if (!cr_found_reg)
                begin
                    id_we       = 1'b1;
                    cr_idx_next = count_reg[IW-1:0];
                    cr_new_next = 1'b1;
                    count_next  = count_reg + cnt_t'(1);
                end
            end
            OP_ADD_CE:
            begin
                if (!ce_found_reg)
                begin
                    if (ce_same)
                    begin
                        ce_idx_next = cr_idx_reg;
                        ce_new_next = cr_new_reg;
                    end
                    else
                    begin
                        id_we       = 1'b1;
                        id_wdata    = ce_id_reg;
                        ce_idx_next = count_reg[IW-1:0];
                        ce_new_next = 1'b1;
                        count_next  = count_reg + cnt_t'(1);
                    end
                end
            end
            OP_ROW1_RD:
            begin
                row_re    = 1'b1;
                row_raddr = ce_idx_reg;
            end
            OP_ROW1_WR:
            begin
                row_we    = 1'b1;
                row_waddr = ce_idx_reg;
                row_wdata = (ce_new_reg ? '0 : row_rd_reg)
                          | (row_t'(1) << cr_idx_reg) | (row_t'(1) << ce_idx_reg);
            end
            OP_ROW2_RD:
            begin
                row_re    = 1'b1;
                row_raddr = cr_idx_reg;
            end
            OP_ROW2_WR:
            begin
                row_we    = 1'b1;
                row_waddr = cr_idx_reg;
                row_wdata = (cr_new_reg ? '0 : row_rd_reg) | (row_t'(1) << cr_idx_reg);
            end
            OP_CL_RDK:
            begin
                row_re    = 1'b1;
                row_raddr = k_reg[IW-1:0];
            end
            OP_CL_LDK:
            begin
                rowk_next = row_rd_reg;
                i_next    = '0;
            end
            OP_CL_ROW:
            begin
                row_re      = 1'b1;
                tag_next    = i_reg[IW-1:0];
                cl_vld_next = 1'b1;
                i_next      = i_reg + cnt_t'(1);
            end
            OP_K_NEXT:
            begin
                k_next = k_reg + cnt_t'(1);
            end
            OP_CHK_INIT:
            begin
                i_next   = '0;
                hit_next = 1'b0;
            end
            OP_CHK_RDI:
            begin
                row_re = 1'b1;
            end
            OP_CHK_LDI:
            begin
                rowi_next = row_rd_reg;
                j_next    = i_reg + cnt_t'(1);
            end
            OP_CHK_ROW:
            begin
                row_re       = 1'b1;
                row_raddr    = j_reg[IW-1:0];
                tag_next     = j_reg[IW-1:0];
                chk_vld_next = 1'b1;
                j_next       = j_reg + cnt_t'(1);
            end
            OP_I_NEXT:
            begin
                i_next = i_reg + cnt_t'(1);
            end
            OP_ID1_RD:
            begin
                id_re = 1'b1;
            end
            OP_ID1_LD:
            begin
                res_first_next = 16'(id_rd_reg);
                id_re          = 1'b1;
                id_raddr       = hit_j_reg;
            end
            OP_ID2_LD:
            begin
                res_second_next = 16'(id_rd_reg);
                res_status_next = STATUS_LOOP;
            end
            OP_SET_NOLOOP:
            begin
                res_status_next = STATUS_NO_LOOP;
            end
            OP_PUSH:
            begin
                rsp_next.status    = res_status_reg;
                rsp_next.first_id  = res_first_reg;
                rsp_next.second_id = res_second_reg;
                rsp_valid_next     = 1'b1;
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (id_we)
        begin
            id_mem[id_waddr] <= id_wdata;
        end
        if (id_re)
        begin
            id_rd_reg <= id_mem[id_raddr];
        end
    end

    always_ff @(posedge clk)
    begin
        if (row_we)
        begin
            row_mem[row_waddr] <= row_wdata;
        end
        if (row_re)
        begin
            row_rd_reg <= row_mem[row_raddr];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            i_reg         <= '0;
            j_reg         <= '0;
            k_reg         <= '0;
            cr_found_reg  <= 1'b0;
            ce_found_reg  <= 1'b0;
            cr_new_reg    <= 1'b0;
            ce_new_reg    <= 1'b0;
            check_reg     <= 1'b0;
            hit_reg       <= 1'b0;
            scan_vld_reg  <= 1'b0;
            cl_vld_reg    <= 1'b0;
            chk_vld_reg   <= 1'b0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            count_reg     <= count_next;
            i_reg         <= i_next;
            j_reg         <= j_next;
            k_reg         <= k_next;
            cr_found_reg  <= cr_found_next;
            ce_found_reg  <= ce_found_next;
            cr_new_reg    <= cr_new_next;
            ce_new_reg    <= ce_new_next;
            check_reg     <= check_next;
            hit_reg       <= hit_next;
            scan_vld_reg  <= scan_vld_next;
            cl_vld_reg    <= cl_vld_next;
            chk_vld_reg   <= chk_vld_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cr_id_reg      <= cr_id_next;
        ce_id_reg      <= ce_id_next;
        cr_idx_reg     <= cr_idx_next;
        ce_idx_reg     <= ce_idx_next;
        tag_reg        <= tag_next;
        hit_j_reg      <= hit_j_next;
        rowk_reg       <= rowk_next;
        rowi_reg       <= rowi_next;
        res_status_reg <= res_status_next;
        res_first_reg  <= res_first_next;
        res_second_reg <= res_second_next;
        rsp_reg        <= rsp_next;
    end

endmodule

// ===== sv/transitive_closure_cycle_check_core.sv =====
// Call-graph loop checker. An add-edge item scans the id table one entry per
// cycle for the nodes in use. A check item runs Warshall's closure one matrix
// row per cycle, then a pair search of up to all node pairs and, on a hit, a
// fetch of the two ids; the reach matrix gives one row read per cycle, which
// sets the pace of these passes. No clearing pass is needed after reset. A
// finished result waits in an output register, and the next item is taken
// meanwhile. Depends on tccc_pkg, tccc_ctrl, tccc_datapath.
`include "transitive_closure_cycle_check_core_macros.svh"

module transitive_closure_cycle_check_core
    import tccc_pkg::*;
#(
    parameter int MAX_NODES = 256,
    parameter int ID_BITS   = 16
)
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      req_valid,
    output logic      req_ready,
    input  tccc_req_t req,
    output logic      rsp_valid,
    input  logic      rsp_ready,
    output tccc_rsp_t rsp
);

    dp_cmd_t    cmd;
    dp_status_t sts;

    tccc_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .sts       (sts),
        .cmd       (cmd)
    );

    tccc_datapath #(
        .MAX_NODES (MAX_NODES),
        .ID_BITS   (ID_BITS)
    ) u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .req       (req),
        .rsp_ready (rsp_ready),
        .rsp       (rsp),
        .rsp_valid (rsp_valid),
        .cmd       (cmd),
        .sts       (sts)
    );

    // A result is only loaded when the output register is free or draining.
    `TCCC_ASSERT_NOW(push_has_room, cmd.op == OP_PUSH, !rsp_valid || rsp_ready, "result overwritten")
    `TCCC_ASSERT_NEXT(push_shows_result, cmd.op == OP_PUSH, rsp_valid, "pushed result not shown")
    `TCCC_ASSERT_NEXT(busy_after_accept, req_valid && req_ready, !req_ready, "accepted while busy")

endmodule
